@@ sv/hkec_pkg.sv @@
package hkec_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned CountWidth = $clog2(DataWidth);

   localparam logic [DataWidth-1:0] ALL_ONES = '1;
   localparam logic [DataWidth-1:0] DIGIT_LIMIT = ALL_ONES >> 4;

   // Key kinds carried on the input tuser.
   localparam logic [1:0] KEY_DIGIT     = 2'd0;
   localparam logic [1:0] KEY_BACKSPACE = 2'd1;
   localparam logic [1:0] KEY_CLEAR     = 2'd2;
   localparam logic [1:0] KEY_OPERATOR  = 2'd3;

   // Operation codes.
   localparam logic [3:0] OPER_EQUALS = 4'd0;
   localparam logic [3:0] OPER_ADD    = 4'd1;
   localparam logic [3:0] OPER_SUB    = 4'd2;
   localparam logic [3:0] OPER_MUL    = 4'd3;
   localparam logic [3:0] OPER_AND    = 4'd4;
   localparam logic [3:0] OPER_OR     = 4'd5;
   localparam logic [3:0] OPER_XOR    = 4'd6;
   localparam logic [3:0] OPER_SHL    = 4'd7;
   localparam logic [3:0] OPER_SHR    = 4'd8;
   localparam logic [3:0] OPER_DIV    = 4'd9;
   localparam logic [3:0] OPER_MOD    = 4'd10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_MOD
   } alu_kind_type;

   typedef struct packed {
      logic                 start;
      alu_kind_type         kind;
      logic [DataWidth-1:0] lhs;
      logic [DataWidth-1:0] rhs;
   } alu_req_type;

   typedef struct packed {
      logic                 done;
      logic [DataWidth-1:0] result;
   } alu_rsp_type;

endpackage

@@ sv/hex_key_entry_calculator_top.sv @@
// Key engine of a 32-bit hexadecimal calculator.
// The req channel carries one key per transfer: tuser holds the key kind
// (digit, backspace, clear, operator), tdata the digit and the operation code.
// Every key produces exactly one rsp transfer with the displayed value, a flag
// that the display was rewritten and a beep flag for a refused digit.
// Keys are handled one at a time; req_tready is low from acceptance until the
// result has been transferred out.
// Digits, backspace, clear and operators that apply add, sub, logic ops,
// shifts, equals or an unnamed code, that apply a divide by zero or that
// come before any digit of a new number have their result valid on rsp in
// the cycle after acceptance. An operator that applies multiply, divide or
// modulo runs on the shared bit-serial unit: its 32 steps, its done register
// and the write-back to the output register lie between acceptance and result.
// If the receiver stalls, the result is held in the output register and no
// new key is taken until it is transferred.
// Reset clears the entry and the first operand, sets the pending operation to
// equals and marks that the next digit starts a new number.
module hex_key_entry_calculator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [3:0] digit, [7:4] operation
   input  logic [1:0]  req_tuser,  // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // [31:0] display_value, [32] display_update,
                                   // [33] beep, [39:34] zero
);

   localparam int unsigned W = hkec_pkg::DataWidth;

   hkec_pkg::state_type state_ff, state_in;

   logic [W-1:0] entry_ff, entry_in;
   logic [W-1:0] first_ff, first_in;
   logic [3:0]   pending_ff, pending_in;
   logic         starting_ff, starting_in;
   logic [W-1:0] out_value_ff, out_value_in;
   logic         out_update_ff, out_update_in;
   logic         out_beep_ff, out_beep_in;

   logic [1:0]   key_op;
   logic [3:0]   key_digit;
   logic [3:0]   key_oper;
   logic         key_accept;
   logic         long_op;
   logic         load_rsp;
   logic [W-1:0] quick_result;
   logic [W-1:0] digit_base;

   hkec_pkg::alu_req_type alu_req;
   hkec_pkg::alu_rsp_type alu_rsp;
   hkec_pkg::alu_kind_type alu_kind;

   assign key_op    = req_tuser;
   assign key_digit = req_tdata[3:0];
   assign key_oper  = req_tdata[7:4];
   assign key_accept = req_tvalid && req_tready;

   hkec_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   // Results of the pending operation that need no shared unit, and the unit's kind.
   always_comb begin
      long_op  = 1'b0;
      alu_kind = hkec_pkg::ALU_MUL;
      case (pending_ff)
         hkec_pkg::OPER_EQUALS: quick_result = entry_ff;
         hkec_pkg::OPER_ADD:    quick_result = first_ff + entry_ff;
         hkec_pkg::OPER_SUB:    quick_result = first_ff - entry_ff;
         hkec_pkg::OPER_AND:    quick_result = first_ff & entry_ff;
         hkec_pkg::OPER_OR:     quick_result = first_ff | entry_ff;
         hkec_pkg::OPER_XOR:    quick_result = first_ff ^ entry_ff;
         hkec_pkg::OPER_SHL: begin
            quick_result = (entry_ff >= W) ? '0 : (first_ff << entry_ff[$clog2(W)-1:0]);
         end
         hkec_pkg::OPER_SHR: begin
            quick_result = (entry_ff >= W) ? '0 : (first_ff >> entry_ff[$clog2(W)-1:0]);
         end
         hkec_pkg::OPER_MUL: begin
            quick_result = '0;
            long_op      = 1'b1;
         end
         hkec_pkg::OPER_DIV, hkec_pkg::OPER_MOD: begin
            // A zero divisor gives all ones without starting the unit.
            quick_result = hkec_pkg::ALL_ONES;
            long_op      = (entry_ff != '0);
            alu_kind     = (pending_ff == hkec_pkg::OPER_DIV) ? hkec_pkg::ALU_DIV
                                                              : hkec_pkg::ALU_MOD;
         end
         default: quick_result = '0;
      endcase
   end

   assign digit_base = starting_ff ? '0 : entry_ff;

   // Key handling and write-back of the shared unit.
   always_comb begin
      entry_in      = entry_ff;
      first_in      = first_ff;
      pending_in    = pending_ff;
      starting_in   = starting_ff;
      out_value_in  = out_value_ff;
      out_update_in = out_update_ff;
      out_beep_in   = out_beep_ff;
      load_rsp      = 1'b0;
      if (key_accept) begin
         load_rsp      = 1'b1;
         out_update_in = 1'b1;
         out_beep_in   = 1'b0;
         case (key_op)
            hkec_pkg::KEY_DIGIT: begin
               if (starting_ff) begin
                  first_in = entry_ff;
               end
               starting_in = 1'b0;
               if (digit_base <= hkec_pkg::DIGIT_LIMIT) begin
                  entry_in = {digit_base[W-5:0], key_digit};
               end else begin
                  entry_in      = digit_base;
                  out_update_in = 1'b0;
                  out_beep_in   = 1'b1;
               end
            end
            hkec_pkg::KEY_BACKSPACE: entry_in = entry_ff >> 4;
            hkec_pkg::KEY_CLEAR:     entry_in = '0;
            default: begin
               if (starting_ff) begin
                  out_update_in = 1'b0;
               end else if (long_op) begin
                  load_rsp = 1'b0;
               end else begin
                  entry_in = quick_result;
               end
               starting_in = 1'b1;
               pending_in  = key_oper;
            end
         endcase
         out_value_in = entry_in;
      end else if (alu_rsp.done) begin
         entry_in      = alu_rsp.result;
         out_value_in  = alu_rsp.result;
         out_update_in = 1'b1;
         out_beep_in   = 1'b0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hkec_pkg::ST_IDLE: begin
            if (key_accept) begin
               state_in = load_rsp ? hkec_pkg::ST_RESULT : hkec_pkg::ST_CALC;
            end
         end
         hkec_pkg::ST_CALC: begin
            if (alu_rsp.done) begin
               state_in = hkec_pkg::ST_RESULT;
            end
         end
         hkec_pkg::ST_RESULT: begin
            if (rsp_tready) begin
               state_in = hkec_pkg::ST_IDLE;
            end
         end
         default: state_in = hkec_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      alu_req.start = 1'b0;
      alu_req.kind  = alu_kind;
      alu_req.lhs   = first_ff;
      alu_req.rhs   = entry_ff;
      unique case (state_ff)
         hkec_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            alu_req.start = key_accept && (key_op == hkec_pkg::KEY_OPERATOR)
                            && !starting_ff && long_op;
         end
         hkec_pkg::ST_CALC:   rsp_tvalid = 1'b0;
         hkec_pkg::ST_RESULT: rsp_tvalid = 1'b1;
         default:             rsp_tvalid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= hkec_pkg::ST_IDLE;
         entry_ff    <= '0;
         first_ff    <= '0;
         pending_ff  <= hkec_pkg::OPER_EQUALS;
         starting_ff <= 1'b1;
      end else begin
         state_ff    <= state_in;
         entry_ff    <= entry_in;
         first_ff    <= first_in;
         pending_ff  <= pending_in;
         starting_ff <= starting_in;
      end
      out_value_ff  <= out_value_in;
      out_update_ff <= out_update_in;
      out_beep_ff   <= out_beep_in;
   end

   assign rsp_tdata = {6'b0, out_beep_ff, out_update_ff, out_value_ff};

endmodule

@@ sv/hkec_alu.sv @@
// Shared shift-and-add / shift-and-subtract unit: one bit of the multiplier or
// the dividend per cycle, so a multiply, divide or modulo takes DataWidth steps.
module hkec_alu (
   input  logic                clock,
   input  logic                reset,
   input  hkec_pkg::alu_req_type req,
   output hkec_pkg::alu_rsp_type rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [hkec_pkg::CountWidth-1:0]    cnt_ff, cnt_in;
   hkec_pkg::alu_kind_type             kind_ff, kind_in;
   logic [hkec_pkg::DataWidth-1:0]     acc_ff, acc_in;
   logic [hkec_pkg::DataWidth-1:0]     shf_ff, shf_in;
   logic [hkec_pkg::DataWidth-1:0]     opnd_ff, opnd_in;
   logic [hkec_pkg::DataWidth:0]       rem_shift;
   logic                               fits;

   assign rem_shift = {acc_ff, shf_ff[hkec_pkg::DataWidth-1]};
   assign fits = rem_shift >= {1'b0, opnd_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      kind_in = kind_ff;
      acc_in  = acc_ff;
      shf_in  = shf_ff;
      opnd_in = opnd_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         kind_in = req.kind;
         acc_in  = '0;
         if (req.kind == hkec_pkg::ALU_MUL) begin
            // Multiplier bits are scanned from the top; the multiplicand stays put.
            shf_in  = req.rhs;
            opnd_in = req.lhs;
         end else begin
            shf_in  = req.lhs;
            opnd_in = req.rhs;
         end
      end else if (busy_ff) begin
         if (kind_ff == hkec_pkg::ALU_MUL) begin
            acc_in = {acc_ff[hkec_pkg::DataWidth-2:0], 1'b0}
                     + (shf_ff[hkec_pkg::DataWidth-1] ? opnd_ff : '0);
            shf_in = {shf_ff[hkec_pkg::DataWidth-2:0], 1'b0};
         end else begin
            if (fits) begin
               acc_in = hkec_pkg::DataWidth'(rem_shift - {1'b0, opnd_ff});
            end else begin
               acc_in = rem_shift[hkec_pkg::DataWidth-1:0];
            end
            shf_in = {shf_ff[hkec_pkg::DataWidth-2:0], fits};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == hkec_pkg::CountWidth'(hkec_pkg::DataWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         kind_ff <= hkec_pkg::ALU_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         kind_ff <= kind_in;
      end
      acc_ff  <= acc_in;
      shf_ff  <= shf_in;
      opnd_ff <= opnd_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = (kind_ff == hkec_pkg::ALU_DIV) ? shf_ff : acc_ff;

endmodule

@@ sim/testbench.sv @@
module testbench;

   // Operation codes beyond the ones named in the package; both are stored as
   // pending and give zero when they are applied.
   localparam logic [3:0] OPER_OTHER   = 4'd11;
   localparam logic [3:0] OPER_UNUSED  = 4'd15;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned KEYS_PER_PHASE = 103;

   typedef struct packed {
      logic [31:0] value;
      logic        update;
      logic        beep;
   } display_type;

   typedef struct {
      logic [1:0]  kind;
      logic [3:0]  digit;
      logic [3:0]  oper;
      bit          typed;
      display_type shown;
   } key_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [3:0] digit, [7:4] operation
   logic [1:0]  req_tuser;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] display_value, [32] display_update, [33] beep

   // Calculator state as predicted from the keys accepted so far.
   logic [31:0] calc_entry;
   logic [31:0] calc_operand;
   logic [3:0]  calc_pending;
   logic        calc_fresh;

   display_type display_queue [$];
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned keys_sent;
   int unsigned results_checked = 0;
   int unsigned refused_digits;
   int unsigned applied_operators;

   // Directed keys. Rows with typed set carry the display value expected at
   // a glance; the rest are checked against the prediction.
   key_row_type directed_keys [26] = '{
      '{hkec_pkg::KEY_DIGIT, 4'hF, hkec_pkg::OPER_EQUALS, 1'b1,
        '{32'h0000000F, 1'b1, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'hF, hkec_pkg::OPER_EQUALS, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'hF, hkec_pkg::OPER_EQUALS, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'hF, hkec_pkg::OPER_EQUALS, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'hF, hkec_pkg::OPER_EQUALS, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'hF, hkec_pkg::OPER_EQUALS, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'hF, hkec_pkg::OPER_EQUALS, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'hF, hkec_pkg::OPER_EQUALS, 1'b1,
        '{32'hFFFFFFFF, 1'b1, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'h0, hkec_pkg::OPER_EQUALS, 1'b1,
        '{32'hFFFFFFFF, 1'b0, 1'b1}},
      '{hkec_pkg::KEY_BACKSPACE, 4'h0, hkec_pkg::OPER_EQUALS, 1'b1,
        '{32'h0FFFFFFF, 1'b1, 1'b0}},
      '{hkec_pkg::KEY_OPERATOR, 4'h0, hkec_pkg::OPER_DIV, 1'b1,
        '{32'h0FFFFFFF, 1'b1, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'h0, hkec_pkg::OPER_EQUALS, 1'b1,
        '{32'h00000000, 1'b1, 1'b0}},
      '{hkec_pkg::KEY_OPERATOR, 4'h0, hkec_pkg::OPER_ADD, 1'b1,
        '{32'hFFFFFFFF, 1'b1, 1'b0}},
      '{hkec_pkg::KEY_OPERATOR, 4'h0, hkec_pkg::OPER_SUB, 1'b1,
        '{32'hFFFFFFFF, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'h3, hkec_pkg::OPER_EQUALS, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_OPERATOR, 4'h0, hkec_pkg::OPER_SHL, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'h2, hkec_pkg::OPER_EQUALS, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'h0, hkec_pkg::OPER_EQUALS, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_OPERATOR, 4'h0, hkec_pkg::OPER_MOD, 1'b1,
        '{32'h00000000, 1'b1, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'h0, hkec_pkg::OPER_EQUALS, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_OPERATOR, 4'h0, OPER_OTHER, 1'b1, '{32'hFFFFFFFF, 1'b1, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'h1, hkec_pkg::OPER_EQUALS, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_OPERATOR, 4'h0, OPER_UNUSED, 1'b1, '{32'h00000000, 1'b1, 1'b0}},
      '{hkec_pkg::KEY_DIGIT, 4'h9, hkec_pkg::OPER_EQUALS, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{hkec_pkg::KEY_OPERATOR, 4'h0, hkec_pkg::OPER_EQUALS, 1'b1,
        '{32'h00000000, 1'b1, 1'b0}},
      '{hkec_pkg::KEY_CLEAR, 4'h0, hkec_pkg::OPER_EQUALS, 1'b1,
        '{32'h00000000, 1'b1, 1'b0}}
   };

   hex_key_entry_calculator_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   function automatic logic [31:0] combine(input logic [31:0] lhs, input logic [3:0] code,
                                           input logic [31:0] rhs);
      case (code)
         hkec_pkg::OPER_EQUALS: return rhs;
         hkec_pkg::OPER_ADD:    return lhs + rhs;
         hkec_pkg::OPER_SUB:    return lhs - rhs;
         hkec_pkg::OPER_MUL:    return lhs * rhs;
         hkec_pkg::OPER_AND:    return lhs & rhs;
         hkec_pkg::OPER_OR:     return lhs | rhs;
         hkec_pkg::OPER_XOR:    return lhs ^ rhs;
         hkec_pkg::OPER_SHL:    return (rhs >= 32) ? 32'd0 : lhs << rhs;
         hkec_pkg::OPER_SHR:    return (rhs >= 32) ? 32'd0 : lhs >> rhs;
         hkec_pkg::OPER_DIV:    return (rhs != 0) ? lhs / rhs : hkec_pkg::ALL_ONES;
         hkec_pkg::OPER_MOD:    return (rhs != 0) ? lhs % rhs : hkec_pkg::ALL_ONES;
         default:               return 32'd0;
      endcase
   endfunction

   // Advances the predicted calculator by one key and returns the display.
   function automatic display_type press_key(input logic [1:0] kind,
                                             input logic [3:0] digit,
                                             input logic [3:0] oper);
      display_type shown;
      shown = '0;
      case (kind)
         hkec_pkg::KEY_DIGIT: begin
            if (calc_fresh) begin
               calc_operand = calc_entry;
               calc_entry = '0;
            end
            calc_fresh = 1'b0;
            if (calc_entry <= hkec_pkg::DIGIT_LIMIT) begin
               calc_entry = {calc_entry[27:0], digit};
               shown.update = 1'b1;
            end else begin
               shown.beep = 1'b1;
            end
         end
         hkec_pkg::KEY_BACKSPACE: begin
            calc_entry = calc_entry >> 4;
            shown.update = 1'b1;
         end
         hkec_pkg::KEY_CLEAR: begin
            calc_entry = '0;
            shown.update = 1'b1;
         end
         default: begin
            if (!calc_fresh) begin
               calc_entry = combine(calc_operand, calc_pending, calc_entry);
               shown.update = 1'b1;
            end
            calc_fresh = 1'b1;
            calc_pending = oper;
         end
      endcase
      shown.value = calc_entry;
      return shown;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 50)
         $display("mismatch in %s on result %0d: got %h, expected %h",
                  what, results_checked, got, want);
   endtask

   task automatic check_display(input logic [39:0] data);
      display_type want;
      if (display_queue.size() == 0) begin
         report_mismatch("unexpected result", data[31:0], 32'd0);
      end else begin
         want = display_queue.pop_front();
         if (data[31:0] !== want.value)
            report_mismatch("display_value", data[31:0], want.value);
         if (data[32] !== want.update)
            report_mismatch("display_update", {31'd0, data[32]}, {31'd0, want.update});
         if (data[33] !== want.beep)
            report_mismatch("beep", {31'd0, data[33]}, {31'd0, want.beep});
      end
      results_checked++;
   endtask

   // Drives one key and records its expected display once the transfer is made.
   task automatic send_key(input logic [1:0] kind, input logic [3:0] digit,
                           input logic [3:0] oper, input bit typed,
                           input display_type typed_shown);
      display_type shown;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'($urandom_range(255));
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {oper, digit};
      req_tuser <= kind;
      do
         @(posedge clock);
      while (!req_tready);
      shown = press_key(kind, digit, oper);
      if (typed)
         shown = typed_shown;
      display_queue.push_back(shown);
      keys_sent++;
      if (shown.beep)
         refused_digits++;
      if (kind == hkec_pkg::KEY_OPERATOR && shown.update)
         applied_operators++;
   endtask

   task automatic send_random_key(input logic [1:0] kind, input logic [3:0] digit,
                                  input logic [3:0] oper);
      send_key(kind, digit, oper, 1'b0, '0);
   endtask

   // Mostly whole numbers followed by an operator, with some stray keys mixed in.
   task automatic run_random(input int unsigned key_total);
      int unsigned first_key;
      int unsigned length;
      int unsigned pick;
      logic [3:0]  oper;
      first_key = keys_sent;
      while (keys_sent - first_key < key_total) begin
         if ($urandom_range(99) < 75) begin
            pick = $urandom_range(11);
            if (pick < 5)
               length = $urandom_range(1, 2);
            else if (pick < 8)
               length = $urandom_range(3, 6);
            else if (pick < 10)
               length = $urandom_range(7, 8);
            else if (pick == 10)
               length = 0;
            else
               length = $urandom_range(9, 10);
            for (int unsigned k = 0; k < length; k++) begin
               pick = $urandom_range(99);
               if (pick < 5)
                  send_random_key(hkec_pkg::KEY_BACKSPACE, 4'($urandom_range(15)),
                                  4'($urandom_range(15)));
               else if (pick < 8)
                  send_random_key(hkec_pkg::KEY_CLEAR, 4'($urandom_range(15)),
                                  4'($urandom_range(15)));
               send_random_key(hkec_pkg::KEY_DIGIT, 4'($urandom_range(15)),
                               4'($urandom_range(15)));
            end
            if ($urandom_range(9) == 0)
               oper = 4'($urandom_range(11, 15));
            else
               oper = 4'($urandom_range(10));
            send_random_key(hkec_pkg::KEY_OPERATOR, 4'($urandom_range(15)), oper);
         end else begin
            send_random_key(2'($urandom_range(3)), 4'($urandom_range(15)),
                            4'($urandom_range(15)));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         if (rsp_tvalid && rsp_tready)
            check_display(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[hex_key_entry_calculator_top] ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      keys_sent = 0;
      refused_digits = 0;
      applied_operators = 0;
      calc_entry = '0;
      calc_operand = '0;
      calc_pending = hkec_pkg::OPER_EQUALS;
      calc_fresh = 1'b1;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_keys[i])
         send_key(directed_keys[i].kind, directed_keys[i].digit, directed_keys[i].oper,
                  directed_keys[i].typed, directed_keys[i].shown);
      run_random(KEYS_PER_PHASE);
      send_idle_pct = 84;
      run_random(KEYS_PER_PHASE);
      send_idle_pct = 0;
      stall_pct = 84;
      run_random(KEYS_PER_PHASE);
      send_idle_pct = 23;
      stall_pct = 23;
      run_random(KEYS_PER_PHASE);
      req_tvalid <= 1'b0;

      while (display_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d keys through four pressure phases: %0d refused digits, %0d %s",
               keys_sent, refused_digits, applied_operators, "applied operators.");
      $display("Compared %0d results, %0d field mismatches.", results_checked, error_count);
      if (error_count == 0 && display_queue.size() == 0)
         $display("[hex_key_entry_calculator_top] OK");
      else
         $display("[hex_key_entry_calculator_top] ERROR");
      $finish;
   end

endmodule
